FILE: design/epid_pkg.sv
// Shared types, constants and the control program of the encoder PID speed loop.
package epid_pkg;

	// field widths
	localparam int TGT_W   = 14;
	localparam int ENC_W   = 16;
	localparam int MS_W    = 16;
	localparam int PWM_W   = 15;
	localparam int SPD_W   = 24;
	localparam int ODO_W   = 32;
	localparam int DELTA_W = 17;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	// datapath widths
	localparam int NUM_W  = 35;          // |delta| * 960000 < 2^35
	localparam int DEN_W  = 32;          // ticks_per_rev * elapsed
	localparam int MA_W   = 17;
	localparam int MB_W   = 27;
	localparam int PROD_W = MA_W + MB_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int FRAC_W = 12;          // Q8.8 gain times Q.4 error
	localparam int SH_W   = ACC_W - FRAC_W;
	localparam int ERR_W  = 25;
	localparam int DIFF_W = ERR_W + 1;
	localparam int TCL_W  = TGT_W + 1;

	localparam logic signed [MB_W-1:0] SPEED_SCALE = MB_W'(60000 * 16);
	localparam logic [NUM_W-1:0] SPD_POS_MAX = NUM_W'((64'd1 << (SPD_W - 1)) - 1);
	localparam logic [NUM_W-1:0] SPD_NEG_MAX = NUM_W'(64'd1 << (SPD_W - 1));
	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'((64'd1 << FRAC_W) - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP,
		REG_KI,
		REG_KD,
		REG_MAX_SPEED,
		REG_PWM_LIMIT,
		REG_INT_LIMIT,
		REG_MOTOR_DIR,
		REG_ENC_INV
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] kp_gain;
		logic [15:0] ki_gain;
		logic [15:0] kd_gain;
		logic [12:0] max_speed;
		logic [14:0] pwm_limit;
		logic [22:0] integral_limit;
		logic        motor_direction;
		logic        encoder_invert;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		kp_gain:         16'd51,
		ki_gain:         16'd128,
		kd_gain:         16'd77,
		max_speed:       13'd5600,
		pwm_limit:       15'd1000,
		integral_limit:  23'd32000,
		motor_direction: 1'b0,
		encoder_invert:  1'b0
	};

	typedef enum logic [2:0] {
		MS_NONE,
		MS_NUM,
		MS_DEN,
		MS_KP,
		MS_KI,
		MS_KD
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef enum logic [1:0] {
		J_NONE,
		J_NO_IN,
		J_DIV_BUSY,
		J_OUT_BUSY
	} cond_t;

	localparam int PC_W = 4;

	typedef struct packed {
		logic            take_in;
		mul_sel_t        mul_sel;
		acc_op_t         acc_op;
		logic            ld_odo;
		logic            ld_num;
		logic            div_start;
		logic            ld_speed;
		logic            ld_err;
		logic            ld_integ;
		logic            ld_shift;
		logic            ld_out;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            last;
	} ctrl_t;

	typedef struct packed {
		logic no_in;
		logic div_busy;
		logic out_blocked;
	} status_t;

	localparam ctrl_t CW_NOP = '{
		take_in:   1'b0,
		mul_sel:   MS_NONE,
		acc_op:    ACC_HOLD,
		ld_odo:    1'b0,
		ld_num:    1'b0,
		div_start: 1'b0,
		ld_speed:  1'b0,
		ld_err:    1'b0,
		ld_integ:  1'b0,
		ld_shift:  1'b0,
		ld_out:    1'b0,
		cond:      J_NONE,
		target:    '0,
		last:      1'b0
	};

	// program steps
	localparam logic [PC_W-1:0] ST_IDLE     = 4'd0;
	localparam logic [PC_W-1:0] ST_NUM      = 4'd1;
	localparam logic [PC_W-1:0] ST_DEN      = 4'd2;
	localparam logic [PC_W-1:0] ST_DIV_GO   = 4'd3;
	localparam logic [PC_W-1:0] ST_DIV_WAIT = 4'd4;
	localparam logic [PC_W-1:0] ST_SPEED    = 4'd5;
	localparam logic [PC_W-1:0] ST_ERR      = 4'd6;
	localparam logic [PC_W-1:0] ST_INTEG    = 4'd7;
	localparam logic [PC_W-1:0] ST_MUL_KI   = 4'd8;
	localparam logic [PC_W-1:0] ST_MUL_KD   = 4'd9;
	localparam logic [PC_W-1:0] ST_ACC_KD   = 4'd10;
	localparam logic [PC_W-1:0] ST_SHIFT    = 4'd11;
	localparam logic [PC_W-1:0] ST_OUT      = 4'd12;

	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t cw;
		cw = CW_NOP;
		unique case (pc)
			ST_IDLE: begin
				cw.take_in = 1'b1;
				cw.cond    = J_NO_IN;
				cw.target  = ST_IDLE;
			end
			ST_NUM: begin
				cw.mul_sel = MS_NUM;
				cw.ld_odo  = 1'b1;
			end
			ST_DEN: begin
				cw.mul_sel = MS_DEN;
				cw.ld_num  = 1'b1;
			end
			ST_DIV_GO: begin
				cw.div_start = 1'b1;
			end
			ST_DIV_WAIT: begin
				cw.cond   = J_DIV_BUSY;
				cw.target = ST_DIV_WAIT;
			end
			ST_SPEED: begin
				cw.ld_speed = 1'b1;
			end
			ST_ERR: begin
				cw.ld_err = 1'b1;
			end
			ST_INTEG: begin
				cw.ld_integ = 1'b1;
				cw.mul_sel  = MS_KP;
			end
			ST_MUL_KI: begin
				cw.acc_op  = ACC_LOAD;
				cw.mul_sel = MS_KI;
			end
			ST_MUL_KD: begin
				cw.acc_op  = ACC_ADD;
				cw.mul_sel = MS_KD;
			end
			ST_ACC_KD: begin
				cw.acc_op = ACC_ADD;
			end
			ST_SHIFT: begin
				cw.ld_shift = 1'b1;
			end
			ST_OUT: begin
				cw.ld_out = 1'b1;
				cw.cond   = J_OUT_BUSY;
				cw.target = ST_OUT;
				cw.last   = 1'b1;
			end
			default: begin
				cw = CW_NOP;
			end
		endcase
		return cw;
	endfunction

endpackage

FILE: design/epid_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module epid_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [epid_pkg::NUM_W-1:0] num,
	input  logic [epid_pkg::DEN_W-1:0] den,
	output logic                       busy,
	output logic [epid_pkg::NUM_W-1:0] quo
);
	import epid_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   sub;
	logic             ge;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign sub     = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? sub[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

`ifndef SYNTHESIS
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0))
		else $error("divider busy with zero count");
`endif

endmodule

FILE: design/epid_seq.sv
// Step counter and control store of the speed loop sequencer.
module epid_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  epid_pkg::status_t status,
	output epid_pkg::ctrl_t   cw
);
	import epid_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	logic            jump;

	assign cw = ucode(pc_q);

	always_comb begin
		unique case (cw.cond)
			J_NONE:     jump = 1'b0;
			J_NO_IN:    jump = status.no_in;
			J_DIV_BUSY: jump = status.div_busy;
			J_OUT_BUSY: jump = status.out_blocked;
			default:    jump = 1'b0;
		endcase
		if (jump) begin
			pc_next = cw.target;
		end else if (cw.last) begin
			pc_next = ST_IDLE;
		end else begin
			pc_next = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

`ifndef SYNTHESIS
	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.take_in && !status.no_in) |=> (pc_q == ST_NUM))
		else $error("accepted request did not start the program");
`endif

endmodule

FILE: design/epid_dp.sv
// Datapath: loop state, shared multiplier, accumulator, divider and output register.
module epid_dp #(
	parameter int TICKS_PER_REV = 1560,
	parameter int DEADBAND      = 40
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  epid_pkg::ctrl_t                     cw,
	input  epid_pkg::cfg_t                      cfg,
	input  logic                                in_valid,
	input  logic signed [epid_pkg::TGT_W-1:0]   target_speed,
	input  logic        [epid_pkg::ENC_W-1:0]   encoder_count,
	input  logic        [epid_pkg::MS_W-1:0]    elapsed_ms,
	input  logic                                out_stall,
	output epid_pkg::status_t                   status,
	output logic                                out_valid,
	output logic        [epid_pkg::PWM_W-1:0]   pwm_a,
	output logic        [epid_pkg::PWM_W-1:0]   pwm_b,
	output logic signed [epid_pkg::SPD_W-1:0]   measured_speed,
	output logic signed [epid_pkg::ODO_W-1:0]   odometer_ticks
);
	import epid_pkg::*;

	localparam logic [15:0]      TPR = 16'(TICKS_PER_REV);
	localparam logic [PWM_W-1:0] DB  = PWM_W'(DEADBAND);

	// loop state
	logic        [ENC_W-1:0]   last_count_q;
	logic signed [ODO_W-1:0]   odo_q;
	logic signed [ERR_W-1:0]   prev_q;
	logic signed [ERR_W-1:0]   integ_q;

	// working registers
	logic signed [TGT_W-1:0]   target_q;
	logic        [MS_W-1:0]    elapsed_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic        [NUM_W-1:0]   num_q;
	logic signed [SPD_W-1:0]   speed_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [SH_W-1:0]    shift_q;

	// output register
	logic                      out_valid_q;
	logic        [PWM_W-1:0]   pwm_a_q;
	logic        [PWM_W-1:0]   pwm_b_q;
	logic signed [SPD_W-1:0]   speed_out_q;
	logic signed [ODO_W-1:0]   odo_out_q;

	logic                      take;
	logic                      out_blocked;
	logic        [ENC_W-1:0]   draw;
	logic signed [DELTA_W-1:0] delta_raw;
	logic signed [DELTA_W-1:0] delta_neg;
	logic signed [DELTA_W-1:0] delta_new;
	logic        [ENC_W-1:0]   delta_mag;
	logic signed [MA_W-1:0]    ma;
	logic signed [MB_W-1:0]    mb;
	logic                      div_busy;
	logic        [NUM_W-1:0]   quo;
	logic        [SPD_W-1:0]   quo_neg;
	logic signed [SPD_W-1:0]   speed_sat;
	logic signed [TCL_W-1:0]   t_ext;
	logic signed [TCL_W-1:0]   ms_pos;
	logic signed [TCL_W-1:0]   ms_neg;
	logic signed [TCL_W-1:0]   t_cl;
	logic signed [DIFF_W-1:0]  isum;
	logic signed [DIFF_W-1:0]  ilim;
	logic signed [DIFF_W-1:0]  ilim_neg;
	logic signed [ERR_W-1:0]   integ_new;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [ACC_W-1:0]   rnd;
	logic signed [SH_W-1:0]    plim;
	logic signed [SH_W-1:0]    plim_neg;
	logic signed [SH_W-1:0]    shift_abs;
	logic        [PWM_W-1:0]   mag_cl;
	logic        [PWM_W-1:0]   mag;
	logic                      to_a;

	assign take        = cw.take_in && in_valid;
	assign out_blocked = out_valid_q && out_stall;

	// tick delta modulo 2^16, read as signed, optionally reversed
	assign draw      = encoder_count - last_count_q;
	assign delta_raw = {draw[ENC_W-1], draw};
	assign delta_neg = -delta_raw;
	assign delta_new = cfg.encoder_invert ? delta_neg : delta_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
		end else if (take) begin
			last_count_q <= encoder_count;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			target_q  <= target_speed;
			elapsed_q <= (elapsed_ms == '0) ? MS_W'(1) : elapsed_ms;
			delta_q   <= delta_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odo_q <= '0;
		end else if (cw.ld_odo) begin
			odo_q <= odo_q + {{(ODO_W-DELTA_W){delta_q[DELTA_W-1]}}, delta_q};
		end
	end

	// shared multiplier, registered
	always_comb begin
		delta_mag = delta_q[DELTA_W-1] ? ENC_W'(-delta_q) : delta_q[ENC_W-1:0];
		unique case (cw.mul_sel)
			MS_NUM: begin
				ma = {1'b0, delta_mag};
				mb = SPEED_SCALE;
			end
			MS_DEN: begin
				ma = {1'b0, TPR};
				mb = {{(MB_W-MS_W){1'b0}}, elapsed_q};
			end
			MS_KP: begin
				ma = {1'b0, cfg.kp_gain};
				mb = {{(MB_W-ERR_W){err_q[ERR_W-1]}}, err_q};
			end
			MS_KI: begin
				ma = {1'b0, cfg.ki_gain};
				mb = {{(MB_W-ERR_W){integ_q[ERR_W-1]}}, integ_q};
			end
			MS_KD: begin
				ma = {1'b0, cfg.kd_gain};
				mb = {{(MB_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		if (cw.ld_num) begin
			num_q <= prod_q[NUM_W-1:0];
		end
	end

	epid_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cw.div_start),
		.num    (num_q),
		.den    (prod_q[DEN_W-1:0]),
		.busy   (div_busy),
		.quo    (quo)
	);

	// quotient magnitude back to a signed, saturated speed
	always_comb begin
		quo_neg = -quo[SPD_W-1:0];
		if (delta_q[DELTA_W-1]) begin
			speed_sat = (quo > SPD_NEG_MAX) ? SPD_NEG_MAX[SPD_W-1:0] : quo_neg;
		end else begin
			speed_sat = (quo > SPD_POS_MAX) ? SPD_POS_MAX[SPD_W-1:0] : quo[SPD_W-1:0];
		end
	end

	// clamped target
	always_comb begin
		t_ext  = {target_q[TGT_W-1], target_q};
		ms_pos = {2'b00, cfg.max_speed};
		ms_neg = -ms_pos;
		if (t_ext > ms_pos) begin
			t_cl = ms_pos;
		end else if (t_ext < ms_neg) begin
			t_cl = ms_neg;
		end else begin
			t_cl = t_ext;
		end
	end

	// clamped integral
	always_comb begin
		isum     = {integ_q[ERR_W-1], integ_q} + {err_q[ERR_W-1], err_q};
		ilim     = {3'b000, cfg.integral_limit};
		ilim_neg = -ilim;
		if (isum > ilim) begin
			integ_new = ilim[ERR_W-1:0];
		end else if (isum < ilim_neg) begin
			integ_new = ilim_neg[ERR_W-1:0];
		end else begin
			integ_new = isum[ERR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cw.ld_speed) begin
			speed_q <= speed_sat;
		end
		if (cw.ld_err) begin
			err_q <= {{(ERR_W-TCL_W){t_cl[TCL_W-1]}}, t_cl} - {speed_q[SPD_W-1], speed_q};
		end
		if (cw.ld_integ) begin
			diff_q <= {err_q[ERR_W-1], err_q} - {prev_q[ERR_W-1], prev_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			integ_q <= '0;
		end else if (cw.ld_integ) begin
			prev_q  <= err_q;
			integ_q <= integ_new;
		end
	end

	// accumulator and truncation toward zero by 2^12
	assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign rnd      = acc_q + (acc_q[ACC_W-1] ? RND_BIAS : '0);

	always_ff @(posedge clk) begin
		unique case (cw.acc_op)
			ACC_LOAD: acc_q <= prod_ext;
			ACC_ADD:  acc_q <= acc_q + prod_ext;
			default:  acc_q <= acc_q;
		endcase
		if (cw.ld_shift) begin
			shift_q <= rnd[ACC_W-1:FRAC_W];
		end
	end

	// saturate, deadband and steer
	always_comb begin
		plim      = {{(SH_W-PWM_W){1'b0}}, cfg.pwm_limit};
		plim_neg  = -plim;
		shift_abs = -shift_q;
		if (shift_q > plim || shift_q < plim_neg) begin
			mag_cl = cfg.pwm_limit;
		end else if (shift_q[SH_W-1]) begin
			mag_cl = shift_abs[PWM_W-1:0];
		end else begin
			mag_cl = shift_q[PWM_W-1:0];
		end
		mag  = (mag_cl < DB) ? '0 : mag_cl;
		to_a = shift_q[SH_W-1] ? !cfg.motor_direction : cfg.motor_direction;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.ld_out && !out_blocked) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.ld_out && !out_blocked) begin
			pwm_a_q     <= to_a ? mag : '0;
			pwm_b_q     <= to_a ? '0 : mag;
			speed_out_q <= speed_q;
			odo_out_q   <= odo_q;
		end
	end

	assign status.no_in       = !in_valid;
	assign status.div_busy    = div_busy;
	assign status.out_blocked = out_blocked;

	assign out_valid      = out_valid_q;
	assign pwm_a          = pwm_a_q;
	assign pwm_b          = pwm_b_q;
	assign measured_speed = speed_out_q;
	assign odometer_ticks = odo_out_q;

`ifndef SYNTHESIS
	a_div_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cw.div_start |-> !div_busy)
		else $error("divider started while busy");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.ld_out && !out_blocked) |=> out_valid_q)
		else $error("result load lost");
`endif

endmodule

FILE: design/encoder_pid_motor_speed_loop_unit.sv
// Top level of the encoder-fed PID motor speed loop: configuration registers and sequencer.
// Each request is one control tick (target speed, raw encoder count, elapsed ms) and gives one
// result: two bridge PWM compare values, the measured speed in rpm Q.4 and the odometer total.
// The speed is formed by the 35-bit restoring divider; the other program steps run around
// one shared 17x27 multiplier. One request is processed at a time; in_stall drops again as
// soon as the result sits in the output register, so the next request is taken while that
// result waits. Configuration writes are always ready and must only be issued while the
// block is idle; indexes above the last register are ignored.
module encoder_pid_motor_speed_loop_unit #(
	parameter int TICKS_PER_REV = 1560,
	parameter int DEADBAND      = 40
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [epid_pkg::TGT_W-1:0]     target_speed,
	input  logic        [epid_pkg::ENC_W-1:0]     encoder_count,
	input  logic        [epid_pkg::MS_W-1:0]      elapsed_ms,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic        [epid_pkg::PWM_W-1:0]     pwm_a,
	output logic        [epid_pkg::PWM_W-1:0]     pwm_b,
	output logic signed [epid_pkg::SPD_W-1:0]     measured_speed,
	output logic signed [epid_pkg::ODO_W-1:0]     odometer_ticks,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [epid_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [epid_pkg::CFG_DATA_W-1:0] cfg_data
);
	import epid_pkg::*;

	cfg_t    cfg_q;
	ctrl_t   cw;
	status_t status;

	assign cfg_ready = 1'b1;
	assign in_stall  = !cw.take_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KP:        cfg_q.kp_gain         <= cfg_data[15:0];
				REG_KI:        cfg_q.ki_gain         <= cfg_data[15:0];
				REG_KD:        cfg_q.kd_gain         <= cfg_data[15:0];
				REG_MAX_SPEED: cfg_q.max_speed       <= cfg_data[12:0];
				REG_PWM_LIMIT: cfg_q.pwm_limit       <= cfg_data[14:0];
				REG_INT_LIMIT: cfg_q.integral_limit  <= cfg_data[22:0];
				REG_MOTOR_DIR: cfg_q.motor_direction <= cfg_data[0];
				REG_ENC_INV:   cfg_q.encoder_invert  <= cfg_data[0];
				default:       cfg_q                 <= cfg_q;
			endcase
		end
	end

	epid_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cw     (cw)
	);

	epid_dp #(
		.TICKS_PER_REV (TICKS_PER_REV),
		.DEADBAND      (DEADBAND)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cw             (cw),
		.cfg            (cfg_q),
		.in_valid       (in_valid),
		.target_speed   (target_speed),
		.encoder_count  (encoder_count),
		.elapsed_ms     (elapsed_ms),
		.out_stall      (out_stall),
		.status         (status),
		.out_valid      (out_valid),
		.pwm_a          (pwm_a),
		.pwm_b          (pwm_b),
		.measured_speed (measured_speed),
		.odometer_ticks (odometer_ticks)
	);

endmodule
